FILE: hw/rtl/cbdp_pkg.sv
// ----------------------------------------------------------------------------
// cbdp_pkg
// shared types and constants for the codebook int4 dot-product engine
// ----------------------------------------------------------------------------
`default_nettype none

package cbdp_pkg;

  // centroid table
  localparam int unsigned NUM_CENTROIDS = 16;
  localparam int unsigned CENT_W        = 16;
  localparam int unsigned NIB_W         = 4;
  localparam int unsigned WBYTE_W       = 8;

  // configuration port
  localparam int unsigned CFG_REGS      = 4;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_SEL_W     = 2;

  // result
  localparam int unsigned DOT_W         = 48;
  localparam int unsigned EXT_W         = 64;

  // number of multiply lanes (even and odd element)
  localparam int unsigned NUM_LANES     = 2;
  localparam int unsigned LANE_EVEN     = 0;
  localparam int unsigned LANE_ODD      = 1;

  typedef logic signed [CENT_W-1:0]            centroid_t;
  typedef centroid_t [NUM_CENTROIDS-1:0]       ctab_t;
  typedef logic [CFG_REGS-1:0][CFG_DATA_W-1:0] cfg_regs_t;

  // control bits that travel along with one request through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cbdp_if.sv
// ----------------------------------------------------------------------------
// cbdp_if
// valid/ready channels of the codebook int4 dot-product engine
// ----------------------------------------------------------------------------
`default_nettype none

interface cbdp_in_if #(
  parameter int unsigned ACT_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic [7:0]                  weight_byte;
  logic signed [ACT_WIDTH-1:0] act_even;
  logic signed [ACT_WIDTH-1:0] act_odd;
  logic                        odd_valid;
  logic                        last_pair;

  modport source (
    output valid, weight_byte, act_even, act_odd, odd_valid, last_pair,
    input  ready
  );
  modport sink (
    input  valid, weight_byte, act_even, act_odd, odd_valid, last_pair,
    output ready
  );
endinterface

interface cbdp_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] dot_sum;
  logic               saturated;

  modport source (output valid, dot_sum, saturated, input ready);
  modport sink (input valid, dot_sum, saturated, output ready);
endinterface

interface cbdp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/codebook_int4_dot_product.sv
// ----------------------------------------------------------------------------
// codebook_int4_dot_product
// dot-product engine for 4-bit codebook-quantized weights
// ----------------------------------------------------------------------------
// path: a last request passes the lane product registers, the pair-sum
// register and the result register before its result is valid
// throughput: one request per cycle, limited by the two multiply lanes
// a stalled result only holds back input once the last request behind it
// reaches the accumulate stage
// reset: centroid table, accumulator and saturation flag clear to zero
// ----------------------------------------------------------------------------
`default_nettype none

module codebook_int4_dot_product #(
  parameter int unsigned ACT_WIDTH = 16,
  parameter int unsigned ACC_WIDTH = 48
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cbdp_cfg_if.sink   cfg_i,
  cbdp_in_if.sink    in_i,
  cbdp_out_if.source out_o
);

  localparam int unsigned PROD_W = cbdp_pkg::CENT_W + ACT_WIDTH;

  // centroid registers, four packed entries per register
  cbdp_pkg::cfg_regs_t cfg_q;
  cbdp_pkg::ctab_t     ctab;

  // stage 1 control (lane products are held inside the lanes)
  cbdp_pkg::stage_ctrl_t s1_d;
  cbdp_pkg::stage_ctrl_t s1_q;
  logic                  s1_take;
  logic                  in_ready;

  // per-lane operands and products
  logic [cbdp_pkg::NIB_W-1:0]   lane_nib  [cbdp_pkg::NUM_LANES];
  logic signed [ACT_WIDTH-1:0]  lane_act  [cbdp_pkg::NUM_LANES];
  logic                         lane_use  [cbdp_pkg::NUM_LANES];
  logic signed [PROD_W-1:0]     lane_prod [cbdp_pkg::NUM_LANES];

  // configuration writes always land at once; indexes past the table drop
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid && (cfg_i.index < cbdp_pkg::CFG_IDX_W'(cbdp_pkg::CFG_REGS))) begin
      cfg_q[cfg_i.index[cbdp_pkg::CFG_SEL_W-1:0]] <= cfg_i.data;
    end
  end

  // same bits, seen as sixteen signed entries with entry 0 lowest
  assign ctab = cbdp_pkg::ctab_t'(cfg_q);

  // even element takes the low nibble, odd element the high nibble
  assign lane_nib[cbdp_pkg::LANE_EVEN] = in_i.weight_byte[cbdp_pkg::NIB_W-1:0];
  assign lane_act[cbdp_pkg::LANE_EVEN] = in_i.act_even;
  assign lane_use[cbdp_pkg::LANE_EVEN] = 1'b1;
  assign lane_nib[cbdp_pkg::LANE_ODD]  =
    in_i.weight_byte[cbdp_pkg::WBYTE_W-1:cbdp_pkg::NIB_W];
  assign lane_act[cbdp_pkg::LANE_ODD]  = in_i.act_odd;
  // unused odd element contributes zero
  assign lane_use[cbdp_pkg::LANE_ODD]  = in_i.odd_valid;

  // stage 1 moves on when it is empty or the merge stage takes its request
  assign in_ready   = !s1_q.valid || s1_take;
  assign in_i.ready = in_ready;

  assign s1_d.valid = in_i.valid;
  assign s1_d.last  = in_i.last_pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (in_ready) begin
      s1_q <= s1_d;
    end
  end

  for (genvar g = 0; g < cbdp_pkg::NUM_LANES; g++) begin : g_lane
    cbdp_lane #(
      .ACT_WIDTH (ACT_WIDTH)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (in_ready && in_i.valid),
      .ctab_i   (ctab),
      .nibble_i (lane_nib[g]),
      .act_i    (lane_act[g]),
      .use_i    (lane_use[g]),
      .prod_o   (lane_prod[g])
    );
  end

  // merge stage: pair sum, saturating accumulate and result register
  cbdp_acc #(
    .ACT_WIDTH (ACT_WIDTH),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_i        (s1_q),
    .prod_even_i (lane_prod[cbdp_pkg::LANE_EVEN]),
    .prod_odd_i  (lane_prod[cbdp_pkg::LANE_ODD]),
    .s1_take_o   (s1_take),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/cbdp_lane.sv
// ----------------------------------------------------------------------------
// cbdp_lane
// one multiply lane: centroid lookup by nibble, times activation, registered
// ----------------------------------------------------------------------------
`default_nettype none

module cbdp_lane #(
  parameter int unsigned ACT_WIDTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       en_i,
  input  wire cbdp_pkg::ctab_t                            ctab_i,
  input  wire logic [cbdp_pkg::NIB_W-1:0]                 nibble_i,
  input  wire logic signed [ACT_WIDTH-1:0]                act_i,
  input  wire logic                                       use_i,
  output logic signed [cbdp_pkg::CENT_W+ACT_WIDTH-1:0]    prod_o
);

  localparam int unsigned PROD_W = cbdp_pkg::CENT_W + ACT_WIDTH;

  cbdp_pkg::centroid_t       cent;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;

  assign cent = ctab_i[nibble_i];

  always_comb begin
    if (use_i) begin
      prod_d = PROD_W'(cent) * PROD_W'(act_i);
    end else begin
      prod_d = '0;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cbdp_acc.sv
// ----------------------------------------------------------------------------
// cbdp_acc
// merge stage: adds the lane products, saturating accumulate, result register
// ----------------------------------------------------------------------------
`default_nettype none

module cbdp_acc #(
  parameter int unsigned ACT_WIDTH = 16,
  parameter int unsigned ACC_WIDTH = 48
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire cbdp_pkg::stage_ctrl_t                    s1_i,
  input  wire logic signed [cbdp_pkg::CENT_W+ACT_WIDTH-1:0] prod_even_i,
  input  wire logic signed [cbdp_pkg::CENT_W+ACT_WIDTH-1:0] prod_odd_i,
  output logic                                          s1_take_o,
  cbdp_out_if.source                                    out_o
);

  localparam int unsigned PROD_W = cbdp_pkg::CENT_W + ACT_WIDTH;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = ((PAIR_W > ACC_WIDTH) ? PAIR_W : ACC_WIDTH) + 1;

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN =
    {{(SUM_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

  cbdp_pkg::stage_ctrl_t         s2_q;
  logic signed [PAIR_W-1:0]      pair_d;
  logic signed [PAIR_W-1:0]      pair_q;
  logic signed [ACC_WIDTH-1:0]   acc_d;
  logic signed [ACC_WIDTH-1:0]   acc_q;
  logic                          sat_q;
  logic signed [SUM_W-1:0]       sum;
  logic                          hit;
  logic signed [cbdp_pkg::EXT_W-1:0] acc_ext;
  logic                          go;
  logic                          adv2;
  logic                          out_valid_q;
  logic signed [cbdp_pkg::DOT_W-1:0] dot_q;
  logic                          osat_q;

  // pair sum of both lanes
  assign pair_d = PAIR_W'(prod_even_i) + PAIR_W'(prod_odd_i);

  // a last request may only leave when the result register has room
  assign go        = !s2_q.last || !out_valid_q || out_o.ready;
  assign adv2      = !s2_q.valid || go;
  assign s1_take_o = adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (adv2) begin
      s2_q <= s1_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_i.valid) begin
      pair_q <= pair_d;
    end
  end

  // saturating accumulate
  always_comb begin
    sum = SUM_W'(acc_q) + SUM_W'(pair_q);
    hit = 1'b0;
    if (sum > ACC_MAX) begin
      acc_d = ACC_WIDTH'(ACC_MAX);
      hit   = 1'b1;
    end else if (sum < ACC_MIN) begin
      acc_d = ACC_WIDTH'(ACC_MIN);
      hit   = 1'b1;
    end else begin
      acc_d = sum[ACC_WIDTH-1:0];
    end
  end

  assign acc_ext = cbdp_pkg::EXT_W'(acc_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else if (s2_q.valid && go) begin
      if (s2_q.last) begin
        acc_q <= '0;
        sat_q <= 1'b0;
      end else begin
        acc_q <= acc_d;
        sat_q <= sat_q | hit;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_q.valid && s2_q.last && go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q.valid && s2_q.last && go) begin
      dot_q  <= acc_ext[cbdp_pkg::DOT_W-1:0];
      osat_q <= sat_q | hit;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.dot_sum   = dot_q;
  assign out_o.saturated = osat_q;

  // a finished dot product leaves the accumulator and flag cleared
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_q.valid && s2_q.last && go) |=> (acc_q == '0 && !sat_q))
    else $error("accumulator not cleared after last request");

  // the flag only rises when a request is accumulated
  a_sat_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sat_q) |-> $past(s2_q.valid && go && !s2_q.last))
    else $error("saturation flag set without an accumulate");

  // a new result only comes from a last request
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_q.valid && s2_q.last))
    else $error("result produced without a last request");

  // a held request keeps its pair sum
  a_hold_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_q.valid && !go) |=> $stable(pair_q) && s2_q.valid)
    else $error("stalled pair sum changed");

endmodule

`default_nettype wire
